[src/btpl_pkg.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix lookup package
// Shared sizes, node layout and the command and status bundles between the
// walk controller and the trie datapath.
// ----------------------------------------------------------------------------
package btpl_pkg;

  localparam int unsigned NODES   = 65536;
  localparam int unsigned IDX_W   = $clog2(NODES);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned HOP_W   = 8;
  localparam int unsigned DEPTH_W = 6;

  localparam logic [LEN_W-1:0]   MAX_LEN   = LEN_W'(ADDR_W);
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(ADDR_W);

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             valid;
    logic [HOP_W-1:0] hop;
  } node_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } sts_t;

endpackage

[src/btpl_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix lookup controller
// Sequences one item at a time: accept, walk one trie level per cycle, then
// hand the result to the output register.
// ----------------------------------------------------------------------------
module btpl_ctrl
  import btpl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e state_d, state_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/btpl_dp.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix lookup datapath
// Holds the node store, the root node, the allocation count, the walk
// registers and the output register.
// ----------------------------------------------------------------------------
module btpl_dp
  import btpl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              kind_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  prefix_len_i,
  input  logic [HOP_W-1:0]  hop_in_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              hit_o,
  output logic [HOP_W-1:0]  hop_out_o,
  output logic              full_res_o
);

  node_t mem_q [NODES];
  node_t rdata_q;
  node_t root_q;

  logic [CNT_W-1:0]   used_q;
  logic [IDX_W-1:0]   cur_q;
  logic               fresh_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;
  logic [HOP_W-1:0]   hop_in_q;
  logic               kind_q;
  logic               found_q;
  logic [HOP_W-1:0]   hop_q;
  logic               full_q;

  logic               out_valid_q;
  logic               out_hit_q;
  logic [HOP_W-1:0]   out_hop_q;
  logic               out_full_q;

  node_t              node_w;
  node_t              wr_data;
  logic               wr_en;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   next_idx;
  logic               at_end;
  logic               store_full;
  logic               full_now;
  logic               alloc;
  logic               done;

  always_comb begin
    if (cur_q == '0) begin
      node_w = root_q;
    end else if (fresh_q) begin
      node_w = '0;
    end else begin
      node_w = rdata_q;
    end
  end

  always_comb begin
    slot       = addr_q[ADDR_W-1] ? node_w.right : node_w.left;
    at_end     = (DEPTH_W'(len_q) == depth_q);
    store_full = (used_q == CNT_W'(NODES));
    full_now   = 1'b0;
    alloc      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = node_w;
    next_idx   = (slot != '0) ? slot : used_q[IDX_W-1:0];
    if (kind_q == KIND_LOOKUP) begin
      done = (depth_q == MAX_DEPTH) || (slot == '0);
    end else begin
      full_now = !at_end && (slot == '0) && store_full;
      done     = at_end || full_now;
      if (at_end) begin
        if ((len_q != '0) && !node_w.valid) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b1;
          wr_data.hop   = hop_in_q;
        end
      end else if (slot == '0) begin
        if (store_full) begin
          wr_en = fresh_q;
        end else begin
          alloc = 1'b1;
          wr_en = 1'b1;
          if (addr_q[ADDR_W-1]) begin
            wr_data.right = used_q[IDX_W-1:0];
          end else begin
            wr_data.left = used_q[IDX_W-1:0];
          end
        end
      end
    end
  end

  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[next_idx];
    if (cmd_i.step && wr_en && (cur_q != '0)) begin
      mem_q[cur_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      used_q  <= CNT_W'(1);
      fresh_q <= 1'b0;
    end else if (cmd_i.load) begin
      fresh_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (wr_en && (cur_q == '0)) begin
        root_q <= wr_data;
      end
      if (alloc) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (!done) begin
        fresh_q <= alloc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q    <= '0;
      depth_q  <= '0;
      addr_q   <= address_i;
      len_q    <= (prefix_len_i > MAX_LEN) ? MAX_LEN : prefix_len_i;
      hop_in_q <= hop_in_i;
      kind_q   <= kind_i;
      found_q  <= 1'b0;
      hop_q    <= '0;
      full_q   <= 1'b0;
    end else if (cmd_i.step) begin
      if ((kind_q == KIND_LOOKUP) && node_w.valid) begin
        found_q <= 1'b1;
        hop_q   <= node_w.hop;
      end
      full_q <= full_now;
      if (!done) begin
        cur_q   <= next_idx;
        depth_q <= depth_q + DEPTH_W'(1);
        addr_q  <= {addr_q[ADDR_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hit_q  <= found_q;
      out_hop_q  <= hop_q;
      out_full_q <= full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign hop_out_o   = out_hop_q;
  assign full_res_o  = out_full_q;

endmodule

[src/binary_trie_prefix_lookup_top.sv]
// ----------------------------------------------------------------------------
// Binary trie prefix lookup
// Unibit trie for IPv4 longest-prefix match with insert and lookup items.
// ----------------------------------------------------------------------------
// One item is worked at a time. The trie is walked one level per clock, with
// one read of the node store per level. A lookup walks at most 33 levels,
// the root included, and an insert walks prefix_len + 1 levels (prefix_len
// capped at 32), or fewer when the store runs out. A new item is accepted
// while the previous result still waits in the output register. The node
// store needs no clearing after reset: the root lives in flops and every
// other node is written in full when it is allocated.
module binary_trie_prefix_lookup_top
  import btpl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: address[31:0], prefix_len[37:32], hop_in[45:38].
  input  logic [47:0] s_axis_tdata_i,
  // Fields from bit 0: kind.
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: hit[0], hop_out[8:1], full_res[9].
  output logic [15:0] m_axis_tdata_o
);

  cmd_t             cmd;
  sts_t             sts;
  logic             hit;
  logic [HOP_W-1:0] hop_out;
  logic             full_res;

  btpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  btpl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (s_axis_tuser_i),
    .address_i    (s_axis_tdata_i[31:0]),
    .prefix_len_i (s_axis_tdata_i[37:32]),
    .hop_in_i     (s_axis_tdata_i[45:38]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .hit_o        (hit),
    .hop_out_o    (hop_out),
    .full_res_o   (full_res)
  );

  assign m_axis_tdata_o = {6'b0, full_res, hop_out, hit};

endmodule
